// ===== rtl/mlhs_pkg.sv =====
// Shared constants and types for the meter link health supervisor.
package mlhs_pkg;

  // Register map indices
  localparam logic [1:0] REG_POLL_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_RETRY_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_FAIL_THRESHOLD  = 2'd2;
  localparam logic [1:0] REG_NOTIFY_INTERVAL = 2'd3;

  // Reset values of the configuration registers
  localparam logic [31:0] POLL_INTERVAL_RST   = 32'd10000;
  localparam logic [31:0] RETRY_INTERVAL_RST  = 32'd15000;
  localparam logic [7:0]  FAIL_THRESHOLD_RST  = 8'd3;
  localparam logic [31:0] NOTIFY_INTERVAL_RST = 32'd60000;

  // Saturation value of the failure counter
  localparam logic [7:0] FAIL_COUNT_MAX = 8'hFF;

  // Input action codes
  localparam logic ACT_TIME_CHECK = 1'b0;
  localparam logic ACT_OUTCOME    = 1'b1;

  // One result beat
  typedef struct packed {
    logic       poll_due;
    logic       meter_fault;
    logic       terminal_disabled;
    logic       disable_pulse;
    logic       enable_pulse;
    logic       fault_notice;
    logic       restore_notice;
    logic [7:0] fail_count;
  } mlhs_result_t;

endpackage

// ===== rtl/meter_link_health_supervisor_core.sv =====
// Meter link health supervisor: poll scheduling, failure counting and notices.
//
// Usage: one instance per meter link.
// Input channel (in_valid/in_stall) carries beats of action, now_ms and poll_ok.
//   action 0 is a time check; out_poll_due says whether a poll is due and, when it
//   is, the matching poll or retry stamp takes now_ms. action 1 reports a poll outcome.
// Result channel (out_valid/out_stall) returns exactly one beat per input beat,
//   in order: the flags, pulses, notices and failure count after that beat.
// Configuration port (cfg_we/cfg_index/cfg_wdata) writes the poll, retry and
//   notify intervals and the failure threshold; write only while idle.
// Path: an accepted beat enters the input register; its result is loaded into
//   the result register once that register is free or draining, and out_valid
//   rises with that load. Throughput is one beat per cycle while the receiver
//   does not stall, set by the single compare and update stage between them.
// Reset (rst_n low, synchronous) empties both registers, clears all state and
//   loads the default intervals and threshold.
// When the receiver stalls, the result beat holds; the input register still
//   takes one more beat, after which in_stall rises until the result moves.
module meter_link_health_supervisor_core
  import mlhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_now_ms,
  input  logic        in_poll_ok,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_poll_due,
  output logic        out_meter_fault,
  output logic        out_terminal_disabled,
  output logic        out_disable_pulse,
  output logic        out_enable_pulse,
  output logic        out_fault_notice,
  output logic        out_restore_notice,
  output logic [7:0]  out_fail_count,
  // configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Configuration registers
  logic [31:0] poll_interval_r;
  logic [31:0] retry_interval_r;
  logic [7:0]  fail_threshold_r;
  logic [31:0] notify_interval_r;

  // Link state
  logic [31:0] last_poll_r,   last_poll_nxt;
  logic [31:0] last_retry_r,  last_retry_nxt;
  logic [31:0] last_notice_r, last_notice_nxt;
  logic [7:0]  fails_r,       fails_nxt;
  logic        disabled_r,    disabled_nxt;
  logic        fault_r,       fault_nxt;
  logic        notice_sent_r, notice_sent_nxt;

  // Input register
  logic        s1_valid_r;
  logic        s1_action_r;
  logic [31:0] s1_now_r;
  logic        s1_ok_r;

  // Result register
  logic         res_valid_r;
  mlhs_result_t res_r, res_nxt;

  logic        advance;
  logic [7:0]  fails_inc;
  logic [31:0] poll_age, retry_age, notice_age;

  // Handshake: the stage advances when the result register is free or draining
  assign advance  = s1_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r   <= POLL_INTERVAL_RST;
      retry_interval_r  <= RETRY_INTERVAL_RST;
      fail_threshold_r  <= FAIL_THRESHOLD_RST;
      notify_interval_r <= NOTIFY_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLL_INTERVAL:   poll_interval_r   <= cfg_wdata;
        REG_RETRY_INTERVAL:  retry_interval_r  <= cfg_wdata;
        REG_FAIL_THRESHOLD:  fail_threshold_r  <= cfg_wdata[7:0];
        REG_NOTIFY_INTERVAL: notify_interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_action_r <= in_action;
      s1_now_r    <= in_now_ms;
      s1_ok_r     <= in_poll_ok;
    end
  end

  // Wrapping ages and saturating increment
  assign poll_age   = s1_now_r - last_poll_r;
  assign retry_age  = s1_now_r - last_retry_r;
  assign notice_age = s1_now_r - last_notice_r;
  assign fails_inc  = (fails_r != FAIL_COUNT_MAX) ? fails_r + 8'd1 : fails_r;

  // Per-beat decision and state update
  always_comb begin
    last_poll_nxt   = last_poll_r;
    last_retry_nxt  = last_retry_r;
    last_notice_nxt = last_notice_r;
    fails_nxt       = fails_r;
    disabled_nxt    = disabled_r;
    fault_nxt       = fault_r;
    notice_sent_nxt = notice_sent_r;
    res_nxt         = '0;

    if (s1_action_r == ACT_TIME_CHECK) begin
      if (disabled_r) begin
        res_nxt.poll_due = (retry_age >= retry_interval_r);
        if (res_nxt.poll_due) last_retry_nxt = s1_now_r;
      end else begin
        res_nxt.poll_due = (poll_age >= poll_interval_r);
        if (res_nxt.poll_due) last_poll_nxt = s1_now_r;
      end
    end else if (s1_ok_r) begin
      // Successful poll: clear count, fault and disable; announce recovery if noticed
      fails_nxt              = '0;
      fault_nxt              = 1'b0;
      res_nxt.restore_notice = notice_sent_r;
      notice_sent_nxt        = 1'b0;
      res_nxt.enable_pulse   = disabled_r;
      disabled_nxt           = 1'b0;
    end else begin
      // Failed poll: count while enabled, disable at threshold
      if (!disabled_r) begin
        fails_nxt = fails_inc;
        if (fails_inc >= fail_threshold_r) begin
          disabled_nxt          = 1'b1;
          res_nxt.disable_pulse = 1'b1;
        end
      end
      fault_nxt = 1'b1;
      // Rate-limited fault notice
      if (!notice_sent_r || (notice_age >= notify_interval_r)) begin
        res_nxt.fault_notice = 1'b1;
        notice_sent_nxt      = 1'b1;
        last_notice_nxt      = s1_now_r;
      end
    end

    res_nxt.meter_fault       = fault_nxt;
    res_nxt.terminal_disabled = disabled_nxt;
    res_nxt.fail_count        = fails_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_poll_r   <= '0;
      last_retry_r  <= '0;
      last_notice_r <= '0;
      fails_r       <= '0;
      disabled_r    <= 1'b0;
      fault_r       <= 1'b0;
      notice_sent_r <= 1'b0;
    end else if (advance) begin
      last_poll_r   <= last_poll_nxt;
      last_retry_r  <= last_retry_nxt;
      last_notice_r <= last_notice_nxt;
      fails_r       <= fails_nxt;
      disabled_r    <= disabled_nxt;
      fault_r       <= fault_nxt;
      notice_sent_r <= notice_sent_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = res_valid_r;
  assign out_poll_due          = res_r.poll_due;
  assign out_meter_fault       = res_r.meter_fault;
  assign out_terminal_disabled = res_r.terminal_disabled;
  assign out_disable_pulse     = res_r.disable_pulse;
  assign out_enable_pulse      = res_r.enable_pulse;
  assign out_fault_notice      = res_r.fault_notice;
  assign out_restore_notice    = res_r.restore_notice;
  assign out_fail_count        = res_r.fail_count;

  // A disabled terminal always carries the fault flag
  a_disabled_implies_fault: assert property (@(posedge clk) disable iff (!rst_n)
    disabled_r |-> fault_r)
    else $error("terminal disabled without fault flag");

  // A disable pulse leaves the terminal disabled and faulted
  a_disable_pulse_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_disable_pulse) |-> (out_terminal_disabled && out_meter_fault))
    else $error("disable pulse without disabled state");

  // Restore and enable only follow a success, which clears the count and fault
  a_restore_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_restore_notice || out_enable_pulse)) |->
      (out_fail_count == 8'd0 && !out_meter_fault && !out_terminal_disabled))
    else $error("restore or enable without cleared state");

  // A held result with a full input register must back-pressure the sender
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res_valid_r && out_stall) |-> in_stall)
    else $error("input not stalled while pipeline is full");

  // A stalled result beat stays put
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(res_r)))
    else $error("stalled result beat changed");

endmodule
